// ----- design/cds_pkg.sv -----
`default_nettype none

package cds_pkg;

    // Field widths
    localparam int DAY_W     = 5;
    localparam int LDAY_W    = 6;
    localparam int MONTH_W   = 4;
    localparam int YEAR_W    = 16;
    localparam int DELTA_W   = 12;

    // Largest number of day steps one add may take
    localparam int MAX_STEP  = 1024;
    localparam int CNT_W     = $clog2(MAX_STEP + 1);
    localparam int CMP_W     = (CNT_W > DELTA_W) ? CNT_W : DELTA_W;

    // Operation codes
    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_ADD  = 1'b1;

    // Calendar constants
    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_APR = 4'd4;
    localparam logic [MONTH_W-1:0] MONTH_JUN = 4'd6;
    localparam logic [MONTH_W-1:0] MONTH_SEP = 4'd9;
    localparam logic [MONTH_W-1:0] MONTH_NOV = 4'd11;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;
    localparam logic [DAY_W-1:0]   DAY_FIRST = 5'd1;
    localparam logic [YEAR_W-1:0]  YEAR_DEFAULT = 16'd2023;

    // Controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_STEP,
        S_DONE
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic load;     // check and store a loaded date
        logic start;    // latch step count and direction
        logic step;     // move the date by one day
        logic capture;  // copy the date into the output word
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic delta_zero;  // incoming delta has no steps
        logic cnt_last;    // one step left
    } t_dp_sts;

    // Days in a month; every fourth year is a leap year
    function automatic logic [DAY_W-1:0] month_len(
        input logic [MONTH_W-1:0] month,
        input logic [YEAR_W-1:0]  year
    );
        logic [DAY_W-1:0] len;
        case (month) inside
            MONTH_FEB: begin
                len = (year[1:0] == 2'b00) ? 5'd29 : 5'd28;
            end
            MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: begin
                len = 5'd30;
            end
            default: begin
                len = 5'd31;
            end
        endcase
        return len;
    endfunction

endpackage

`default_nettype wire

// ----- design/cds_ctrl.sv -----
`default_nettype none

module cds_ctrl
    import cds_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    input  wire logic    i_func,
    input  wire logic    i_out_stall,
    input  wire t_dp_sts i_sts,
    output logic         o_in_stall,
    output logic         o_out_valid,
    output t_dp_cmd      o_cmd
);

    t_state r_state, n_state;
    logic   r_out_vld, n_out_vld;
    logic   accept;
    logic   out_free;

    assign accept   = i_in_valid && !o_in_stall;
    assign out_free = !r_out_vld || !i_out_stall;

    // State and output-valid registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
        end
    end

    // Next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            S_IDLE: begin
                // input is never stalled here, so valid alone takes the word
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    if (i_func == FUNC_LOAD) begin
                        o_cmd.load = 1'b1;
                        n_state    = S_DONE;
                    end else begin
                        o_cmd.start = 1'b1;
                        n_state     = i_sts.delta_zero ? S_DONE : S_STEP;
                    end
                end
            end
            S_STEP: begin
                o_cmd.step = 1'b1;
                if (i_sts.cnt_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Output word valid: set on capture, cleared when taken
    always_comb begin
        if (o_cmd.capture) begin
            n_out_vld = 1'b1;
        end else if (!i_out_stall) begin
            n_out_vld = 1'b0;
        end else begin
            n_out_vld = r_out_vld;
        end
    end

    assign o_out_valid = r_out_vld;

    // Never overwrite a word still held by the receiver
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.capture |-> (!r_out_vld || !i_out_stall))
        else $error("output word overwritten while stalled");

    // A nonzero add goes to the step loop
    a_add_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_func == FUNC_ADD && !i_sts.delta_zero) |=> r_state == S_STEP)
        else $error("add did not enter stepping");

    // Every captured word shows up as valid
    a_capture_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.capture |=> r_out_vld)
        else $error("captured word not marked valid");

endmodule

`default_nettype wire

// ----- design/cds_dp.sv -----
`default_nettype none

module cds_dp
    import cds_pkg::*;
(
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire t_dp_cmd                   i_cmd,
    input  wire logic [LDAY_W-1:0]         i_load_day,
    input  wire logic [MONTH_W-1:0]        i_load_month,
    input  wire logic [YEAR_W-1:0]         i_load_year,
    input  wire logic signed [DELTA_W-1:0] i_day_delta,
    output t_dp_sts                        o_sts,
    output logic [DAY_W-1:0]               o_out_day,
    output logic [MONTH_W-1:0]             o_out_month,
    output logic [YEAR_W-1:0]              o_out_year,
    output logic                           o_date_valid
);

    logic [DAY_W-1:0]   r_day, n_day;
    logic [MONTH_W-1:0] r_month, n_month;
    logic [YEAR_W-1:0]  r_year, n_year;
    logic               r_vmark, n_vmark;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic               r_neg, n_neg;

    logic [DAY_W-1:0]   r_o_day;
    logic [MONTH_W-1:0] r_o_month;
    logic [YEAR_W-1:0]  r_o_year;
    logic               r_o_vmark;

    logic               load_ok;
    logic [DELTA_W-1:0] mag;
    logic [CMP_W-1:0]   mag_ext;
    logic [CNT_W-1:0]   sat_cnt;
    logic [DAY_W-1:0]   cur_len;
    logic [MONTH_W-1:0] prev_month;
    logic [YEAR_W-1:0]  prev_year;

    // Load check
    assign load_ok = (i_load_month >= MONTH_JAN) && (i_load_month <= MONTH_DEC)
                  && (i_load_day != '0)
                  && (i_load_day <= {1'b0, month_len(i_load_month, i_load_year)});

    // Step count: magnitude of delta, saturated
    assign mag     = i_day_delta[DELTA_W-1] ? (DELTA_W'(0) - DELTA_W'(i_day_delta))
                                            : DELTA_W'(i_day_delta);
    assign mag_ext = CMP_W'(mag);
    assign sat_cnt = (mag_ext > CMP_W'(MAX_STEP)) ? CNT_W'(MAX_STEP) : CNT_W'(mag_ext);

    assign o_sts.delta_zero = (i_day_delta == '0);
    assign o_sts.cnt_last   = (r_cnt == CNT_W'(1));

    // Neighbors of the current date
    assign cur_len    = month_len(r_month, r_year);
    assign prev_month = (r_month <= MONTH_JAN) ? MONTH_DEC : r_month - MONTH_W'(1);
    assign prev_year  = (r_month <= MONTH_JAN) ? r_year - YEAR_W'(1) : r_year;

    // Date and counter next values
    always_comb begin
        n_day   = r_day;
        n_month = r_month;
        n_year  = r_year;
        n_vmark = r_vmark;
        n_cnt   = r_cnt;
        n_neg   = r_neg;
        if (i_cmd.load) begin
            if (load_ok) begin
                n_day   = DAY_W'(i_load_day);
                n_month = i_load_month;
                n_year  = i_load_year;
                n_vmark = 1'b1;
            end else begin
                n_day   = DAY_FIRST;
                n_month = MONTH_JAN;
                n_year  = YEAR_DEFAULT;
                n_vmark = 1'b0;
            end
        end else if (i_cmd.start) begin
            n_cnt = sat_cnt;
            n_neg = i_day_delta[DELTA_W-1];
        end else if (i_cmd.step) begin
            n_cnt = r_cnt - CNT_W'(1);
            if (r_neg) begin
                if (r_day <= DAY_FIRST) begin
                    n_month = prev_month;
                    n_year  = prev_year;
                    n_day   = month_len(prev_month, prev_year);
                end else begin
                    n_day = r_day - DAY_W'(1);
                end
            end else begin
                if (r_day >= cur_len) begin
                    n_day = DAY_FIRST;
                    if (r_month >= MONTH_DEC) begin
                        n_month = MONTH_JAN;
                        n_year  = r_year + YEAR_W'(1);
                    end else begin
                        n_month = r_month + MONTH_W'(1);
                    end
                end else begin
                    n_day = r_day + DAY_W'(1);
                end
            end
        end
    end

    // Date state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_day   <= DAY_FIRST;
            r_month <= MONTH_JAN;
            r_year  <= YEAR_DEFAULT;
            r_vmark <= 1'b1;
            r_cnt   <= '0;
            r_neg   <= 1'b0;
        end else begin
            r_day   <= n_day;
            r_month <= n_month;
            r_year  <= n_year;
            r_vmark <= n_vmark;
            r_cnt   <= n_cnt;
            r_neg   <= n_neg;
        end
    end

    // Output word
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_o_day   <= r_day;
            r_o_month <= r_month;
            r_o_year  <= r_year;
            r_o_vmark <= r_vmark;
        end
    end

    assign o_out_day    = r_o_day;
    assign o_out_month  = r_o_month;
    assign o_out_year   = r_o_year;
    assign o_date_valid = r_o_vmark;

    // Stored date stays a real date
    a_month_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_month >= MONTH_JAN) && (r_month <= MONTH_DEC))
        else $error("month out of range");

    a_day_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_day >= DAY_FIRST) && (r_day <= cur_len))
        else $error("day out of range for month");

    // Stepping never touches the valid mark
    a_step_keeps_mark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.step |=> r_vmark == $past(r_vmark))
        else $error("valid mark changed by a step");

endmodule

`default_nettype wire

// ----- design/calendar_date_stepper.sv -----
`default_nettype none

// Calendar date stepper: holds one date and a valid mark.
// Input channel (i_in_valid / o_in_stall) carries one word: i_func selects a
// load (check and store i_load_day/month/year) or an add (move the date by
// signed i_day_delta days, magnitude saturated to MAX_STEP).
// Output channel (o_out_valid / i_out_stall) returns one word per input word:
// the date after the operation and the valid mark of the last load.
// A load is checked and stored in the date registers, then copied to the
// output register. An add latches its saturated step count n, then one
// shared day-step unit moves the date one day per cycle for n steps, and
// the date is copied to the output register. One word is in work at a
// time. The next word is taken once the result has moved into the output
// register, which may still be waiting on the receiver. If the receiver
// stalls with a word held, the finished result waits in the date registers
// and o_in_stall stays high. Reset (synchronous, active low) sets the date to
// 01/01/2023 with the valid mark set and empties the output register.
module calendar_date_stepper
    import cds_pkg::*;
(
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_in_valid,
    output logic                           o_in_stall,
    input  wire logic                      i_func,
    input  wire logic [LDAY_W-1:0]         i_load_day,
    input  wire logic [MONTH_W-1:0]        i_load_month,
    input  wire logic [YEAR_W-1:0]         i_load_year,
    input  wire logic signed [DELTA_W-1:0] i_day_delta,
    output logic                           o_out_valid,
    input  wire logic                      i_out_stall,
    output logic [DAY_W-1:0]               o_out_day,
    output logic [MONTH_W-1:0]             o_out_month,
    output logic [YEAR_W-1:0]              o_out_year,
    output logic                           o_date_valid
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    // Sequencer
    cds_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_func      (i_func),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd)
    );

    // Date registers and day-step unit
    cds_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_load_day   (i_load_day),
        .i_load_month (i_load_month),
        .i_load_year  (i_load_year),
        .i_day_delta  (i_day_delta),
        .o_sts        (sts),
        .o_out_day    (o_out_day),
        .o_out_month  (o_out_month),
        .o_out_year   (o_out_year),
        .o_date_valid (o_date_valid)
    );

endmodule

`default_nettype wire
